FILE: rtl/tct_pkg.sv
`default_nettype none
package tct_pkg;

  localparam logic [1:0] CMD_TOUCH = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // one table slot, also the payload of a result beat
  typedef struct packed {
    logic [31:0]        id;
    logic [15:0]        order;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic               pressed;
    logic               released;
  } entry_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        contact_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic               flag_down;
    logic               flag_up;
    logic               flag_move;
    logic [15:0]        query_order;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    entry_t     ent;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/touch_contact_table_top.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | command, contact_id, pos, flags, query_order
// out     | output    | out_valid/out_ready | status, entry_id, cur/last pos, flags, order
//
// One item at a time. Touch, query and frame sweep the slots in use, reading one slot
// per cycle, since the table memory has one read port.
// Reset clears the slot count, order counter and sequencer; slot memory is not cleared.
// A result waiting in the output register does not block the next item.
`default_nettype none
module touch_contact_table_top import tct_pkg::*; #(
  parameter int MAX_CONTACTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic [31:0]        in_contact_id,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic               in_flag_down,
  input  wire logic               in_flag_up,
  input  wire logic               in_flag_move,
  input  wire logic [15:0]        in_query_order,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic [31:0]             out_entry_id,
  output logic signed [23:0]      out_cur_x,
  output logic signed [23:0]      out_cur_y,
  output logic signed [23:0]      out_last_x,
  output logic signed [23:0]      out_last_y,
  output logic                    out_is_pressed,
  output logic                    out_is_released,
  output logic [15:0]             out_arrival_order
);

  localparam int AW = $clog2(MAX_CONTACTS);

  in_item_t      in_item;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          out_valid_r;
  result_t       out_r;

  assign in_item = '{command: in_command, contact_id: in_contact_id,
                     pos_x: in_pos_x, pos_y: in_pos_y, flag_down: in_flag_down,
                     flag_up: in_flag_up, flag_move: in_flag_move,
                     query_order: in_query_order};

  tct_seq #(
    .MAX_CONTACTS(MAX_CONTACTS),
    .AW          (AW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  tct_mem #(
    .DEPTH(MAX_CONTACTS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output register: takes a new beat when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_entry_id      = out_r.ent.id;
  assign out_cur_x         = out_r.ent.x;
  assign out_cur_y         = out_r.ent.y;
  assign out_last_x        = out_r.ent.px;
  assign out_last_y        = out_r.ent.py;
  assign out_is_pressed    = out_r.ent.pressed;
  assign out_is_released   = out_r.ent.released;
  assign out_arrival_order = out_r.ent.order;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("sequencer ready while holding a result");

  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid)
    else $error("result beat lost at output register");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      !out_is_pressed && !out_is_released && out_arrival_order == 16'd0)
    else $error("dropped event carries entry data");

  a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MISS |-> out_entry_id == 32'd0)
    else $error("query miss carries entry data");

endmodule
`default_nettype wire

FILE: rtl/tct_mem.sv
`default_nettype none
module tct_mem import tct_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/tct_seq.sv
`default_nettype none
module tct_seq import tct_pkg::*; #(
  parameter int MAX_CONTACTS = 16,
  parameter int AW           = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire in_item_t      in_item,
  output logic               res_valid,
  input  wire logic          res_ready,
  output result_t            res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output entry_t             mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  wire entry_t        mem_rdata
);

  localparam int CW = $clog2(MAX_CONTACTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FRAME, S_RESULT} state_t;

  state_t        state_r;
  in_item_t      item_r;
  logic [CW-1:0] ra_r;      // next slot to read
  logic          dv_r;      // mem_rdata holds a valid slot (slot da_r in a scan)
  logic [AW-1:0] da_r;
  logic [CW-1:0] w_r;       // compaction write pointer
  logic [CW-1:0] n_r;       // slots in use, packed from 0
  logic [15:0]   cnt_r;     // arrival order counter
  logic [1:0]    status_r;
  entry_t        ent_r;
  logic          wr_pend_r;
  logic [AW-1:0] wr_idx_r;

  logic   issue;
  logic   match;
  logic   hit;
  logic   scan_end;
  entry_t tent;
  entry_t full_ent;
  entry_t frame_ent;

  assign issue     = (ra_r < n_r);
  assign match     = (item_r.command == CMD_TOUCH) ?
                     (mem_rdata.id == item_r.contact_id) :
                     (mem_rdata.order == item_r.query_order);
  assign hit       = dv_r && match;
  assign scan_end  = !dv_r && (ra_r == n_r);
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = '{status: status_r, ent: ent_r};
  assign mem_raddr = ra_r[AW-1:0];

  // touched entry: matched slot or a fresh one, then down, up, move
  always_comb begin
    if (hit) begin
      tent = mem_rdata;
    end else begin
      tent       = '0;
      tent.id    = item_r.contact_id;
      tent.order = cnt_r;
    end
    if (item_r.flag_down) begin
      tent.x       = item_r.pos_x;
      tent.y       = item_r.pos_y;
      tent.px      = item_r.pos_x;
      tent.py      = item_r.pos_y;
      tent.pressed = 1'b1;
    end
    if (item_r.flag_up) begin
      tent.released = 1'b1;
    end
    if (item_r.flag_move) begin
      tent.x = item_r.pos_x;
      tent.y = item_r.pos_y;
    end
    full_ent    = '0;
    full_ent.id = item_r.contact_id;
    frame_ent         = mem_rdata;
    frame_ent.px      = mem_rdata.x;
    frame_ent.py      = mem_rdata.y;
    frame_ent.pressed = 1'b0;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx_r;
    mem_wdata = ent_r;
    if (state_r == S_FRAME) begin
      mem_we    = dv_r && !mem_rdata.released;
      mem_waddr = w_r[AW-1:0];
      mem_wdata = frame_ent;
    end else if (state_r == S_RESULT) begin
      mem_we = wr_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      n_r       <= '0;
      cnt_r     <= '0;
      wr_pend_r <= 1'b0;
      dv_r      <= 1'b0;
      ra_r      <= '0;
      w_r       <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_item;
            ra_r   <= '0;
            dv_r   <= 1'b0;
            w_r    <= '0;
            case (in_item.command)
              CMD_TOUCH, CMD_QUERY: begin
                state_r <= S_SCAN;
              end
              CMD_FRAME: begin
                if (n_r == '0) begin
                  cnt_r <= '0;
                end
                state_r <= S_FRAME;
              end
              default: begin
                status_r  <= ST_OK;
                ent_r     <= '0;
                wr_pend_r <= 1'b0;
                state_r   <= S_RESULT;
              end
            endcase
          end
        end
        S_SCAN: begin
          ra_r <= issue ? ra_r + CW'(1) : ra_r;
          dv_r <= issue;
          da_r <= ra_r[AW-1:0];
          if (hit || scan_end) begin
            state_r <= S_RESULT;
            if (item_r.command == CMD_QUERY) begin
              status_r  <= hit ? ST_OK : ST_MISS;
              ent_r     <= hit ? mem_rdata : entry_t'('0);
              wr_pend_r <= 1'b0;
            end else if (!hit && n_r == CW'(MAX_CONTACTS)) begin
              status_r  <= ST_FULL;
              ent_r     <= full_ent;
              wr_pend_r <= 1'b0;
            end else begin
              status_r  <= ST_OK;
              ent_r     <= tent;
              wr_pend_r <= 1'b1;
              wr_idx_r  <= hit ? da_r : n_r[AW-1:0];
              if (!hit) begin
                n_r <= n_r + CW'(1);
                if (cnt_r != 16'hFFFF) begin
                  cnt_r <= cnt_r + 16'd1;
                end
              end
            end
          end
        end
        S_FRAME: begin
          ra_r <= issue ? ra_r + CW'(1) : ra_r;
          dv_r <= issue;
          if (dv_r && !mem_rdata.released) begin
            w_r <= w_r + CW'(1);
          end
          if (scan_end) begin
            n_r       <= w_r;
            status_r  <= ST_OK;
            ent_r     <= '0;
            wr_pend_r <= 1'b0;
            state_r   <= S_RESULT;
          end
        end
        S_RESULT: begin
          wr_pend_r <= 1'b0;  // write-back lands in the first result cycle
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb_touch_contact_table_top.sv
`timescale 1ns / 1ps
module tb_touch_contact_table_top;
  import tct_pkg::*;

  localparam int          MAXC        = 16;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          CYCLE_LIMIT = 500_000;
  localparam int          END_WAIT    = 40;
  localparam int          HOLD_CYCLES = 300;
  localparam int          RAND_ITEMS  = 1380;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_command = '0;
  logic [31:0]        in_contact_id = '0;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_y = '0;
  logic               in_flag_down = 1'b0;
  logic               in_flag_up = 1'b0;
  logic               in_flag_move = 1'b0;
  logic [15:0]        in_query_order = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [31:0]        out_entry_id;
  logic signed [23:0] out_cur_x;
  logic signed [23:0] out_cur_y;
  logic signed [23:0] out_last_x;
  logic signed [23:0] out_last_y;
  logic               out_is_pressed;
  logic               out_is_released;
  logic [15:0]        out_arrival_order;

  touch_contact_table_top #(.MAX_CONTACTS(MAXC)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_contact_id    (in_contact_id),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_flag_down     (in_flag_down),
    .in_flag_up       (in_flag_up),
    .in_flag_move     (in_flag_move),
    .in_query_order   (in_query_order),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_id     (out_entry_id),
    .out_cur_x        (out_cur_x),
    .out_cur_y        (out_cur_y),
    .out_last_x       (out_last_x),
    .out_last_y       (out_last_y),
    .out_is_pressed   (out_is_pressed),
    .out_is_released  (out_is_released),
    .out_arrival_order(out_arrival_order)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow contact table, kept packed like the block's
  entry_t      shadow_tbl [MAXC];
  int          shadow_cnt = 0;
  logic [15:0] shadow_order = '0;

  in_item_t    pending_items [$];
  result_t     expected_results [$];
  in_item_t    cur_item;
  int          gap_cnt = 0;
  bit          idle_en = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_cnt = 0;
  int          stall_cnt = 0;
  int          fail_cnt = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_full = 0;
  int          n_miss = 0;
  int          cyc_cnt = 0;
  result_t     want_r;

  function automatic result_t table_predict(input in_item_t it);
    result_t r;
    int      hit;
    int      w;
    int      s;
    r   = '0;
    hit = -1;
    case (it.command)
      CMD_TOUCH: begin
        for (s = 0; s < shadow_cnt; s++)
          if (hit < 0 && shadow_tbl[s].id == it.contact_id) hit = s;
        if (hit < 0 && shadow_cnt >= MAXC) begin
          r.status = ST_FULL;
          r.ent.id = it.contact_id;
        end else begin
          if (hit < 0) begin
            hit = shadow_cnt;
            shadow_cnt++;
            shadow_tbl[hit]       = '0;
            shadow_tbl[hit].id    = it.contact_id;
            shadow_tbl[hit].order = shadow_order;
            if (shadow_order != 16'hFFFF) shadow_order++;
          end
          // flags apply down, then up, then move
          if (it.flag_down) begin
            shadow_tbl[hit].x       = it.pos_x;
            shadow_tbl[hit].y       = it.pos_y;
            shadow_tbl[hit].px      = it.pos_x;
            shadow_tbl[hit].py      = it.pos_y;
            shadow_tbl[hit].pressed = 1'b1;
          end
          if (it.flag_up) shadow_tbl[hit].released = 1'b1;
          if (it.flag_move) begin
            shadow_tbl[hit].x = it.pos_x;
            shadow_tbl[hit].y = it.pos_y;
          end
          r.status = ST_OK;
          r.ent    = shadow_tbl[hit];
        end
      end
      CMD_FRAME: begin
        if (shadow_cnt == 0) shadow_order = '0;
        w = 0;
        for (s = 0; s < shadow_cnt; s++) begin
          if (!shadow_tbl[s].released) begin
            shadow_tbl[w]         = shadow_tbl[s];
            shadow_tbl[w].px      = shadow_tbl[w].x;
            shadow_tbl[w].py      = shadow_tbl[w].y;
            shadow_tbl[w].pressed = 1'b0;
            w++;
          end
        end
        shadow_cnt = w;
      end
      CMD_QUERY: begin
        for (s = 0; s < shadow_cnt; s++)
          if (hit < 0 && shadow_tbl[s].order == it.query_order) hit = s;
        if (hit < 0) r.status = ST_MISS;
        else r.ent = shadow_tbl[hit];
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      gap_cnt      <= 0;
      shadow_cnt   = 0;
      shadow_order = '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results = {expected_results, table_predict(cur_item)};
        n_in++;
      end
      if (!in_valid || in_ready) begin
        if (gap_cnt != 0) begin
          gap_cnt  <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
          gap_cnt  <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          cur_item       = pending_items.pop_front();
          in_command     <= cur_item.command;
          in_contact_id  <= cur_item.contact_id;
          in_pos_x       <= cur_item.pos_x;
          in_pos_y       <= cur_item.pos_y;
          in_flag_down   <= cur_item.flag_down;
          in_flag_up     <= cur_item.flag_up;
          in_flag_move   <= cur_item.flag_move;
          in_query_order <= cur_item.query_order;
          in_valid       <= 1'b1;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s: expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // monitor and result-side flow control
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (expected_results.size() == 0) begin
          $display("%0t ERROR unexpected result beat: expected none, actual status %0d id %h",
                   $time, out_status, out_entry_id);
          fail_cnt++;
        end else begin
          want_r = expected_results.pop_front();
          if (want_r.status == ST_FULL) n_full++;
          if (want_r.status == ST_MISS) n_miss++;
          check_field("status", want_r.status, out_status);
          check_field("entry_id", want_r.ent.id, out_entry_id);
          check_field("cur_x", want_r.ent.x, out_cur_x);
          check_field("cur_y", want_r.ent.y, out_cur_y);
          check_field("last_x", want_r.ent.px, out_last_x);
          check_field("last_y", want_r.ent.py, out_last_y);
          check_field("is_pressed", want_r.ent.pressed, out_is_pressed);
          check_field("is_released", want_r.ent.released, out_is_released);
          check_field("arrival_order", want_r.ent.order, out_arrival_order);
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack  <= hold_req;
        hold_cnt  <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt <= stall_cnt - 1;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_cnt <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cyc_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [31:0] id,
                      input logic [23:0] x, input logic [23:0] y,
                      input logic d, input logic u, input logic m,
                      input logic [15:0] q);
    in_item_t it;
    it.command     = cmd;
    it.contact_id  = id;
    it.pos_x       = x;
    it.pos_y       = y;
    it.flag_down   = d;
    it.flag_up     = u;
    it.flag_move   = m;
    it.query_order = q;
    while (pending_items.size() >= 8) @(negedge clk);
    pending_items = {pending_items, it};
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] id_pool [24];
    logic [31:0] live_ids [$];
    int          pool_n;
    int          i;
    int          k;
    int          pick;
    logic [15:0] q;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, flag combinations, full table
    send(CMD_FRAME, $urandom, $urandom, $urandom, 1'b1, 1'b1, 1'b1, $urandom);
    send(CMD_QUERY, $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b0, 16'd0);
    send(CMD_TOUCH, 32'd0, 24'h123456, 24'h654321, 1'b0, 1'b0, 1'b0, 16'hFFFF);
    send(CMD_TOUCH, 32'hFFFF_FFFF, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0, 1'b0, 16'd0);
    send(CMD_TOUCH, 32'hFFFF_FFFF, 24'h800000, 24'h7FFFFF, 1'b0, 1'b0, 1'b1, 16'd0);
    send(CMD_TOUCH, 32'd0, 24'hFFFFFF, 24'h000001, 1'b1, 1'b1, 1'b0, 16'd0);
    send(CMD_TOUCH, 32'd0, 24'h0ABCDE, 24'hF54321, 1'b1, 1'b1, 1'b1, 16'd0);
    send(CMD_UNUSED, 32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    send(CMD_QUERY, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd1);
    send(CMD_QUERY, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'hFFFF);
    send(CMD_FRAME, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd0);
    send(CMD_QUERY, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd1);
    for (i = 0; i < MAXC - 1; i++)
      send(CMD_TOUCH, 32'd100 + i, $urandom, $urandom, 1'b1, 1'b0, 1'b0, $urandom);
    send(CMD_TOUCH, 32'h8000_0000, $urandom, $urandom, 1'b1, 1'b0, 1'b1, $urandom);
    send(CMD_TOUCH, 32'd105, $urandom, $urandom, 1'b0, 1'b1, 1'b1, $urandom);
    wait_drained();

    // random traffic over small pools of ids so the table fills and drains
    idle_en = 1'b1;
    pool_n  = 4;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 200 == 0) begin
        pool_n = $urandom_range(2, 24);
        for (k = 0; k < 24; k++) id_pool[k] = $urandom;
        if ($urandom_range(0, 1)) id_pool[0] = 32'd0;
        if ($urandom_range(0, 1)) id_pool[1] = 32'hFFFF_FFFF;
      end
      if (i % 150 == 0) idle_en = $urandom_range(0, 2) != 0;
      // long receiver hold-off while offers keep coming
      if (i == 100) hold_req = ~hold_req;
      if (i % 350 == 349) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send(CMD_TOUCH, id_pool[$urandom_range(0, pool_n - 1)], $urandom, $urandom,
             $urandom_range(0, 2) == 0, $urandom_range(0, 4) == 0,
             $urandom_range(0, 1), $urandom);
      end else if (pick < 75) begin
        send(CMD_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom);
      end else if (pick < 95) begin
        k = $urandom_range(0, 9);
        if (k < 6 && shadow_cnt > 0) q = shadow_tbl[$urandom_range(0, shadow_cnt - 1)].order;
        else if (k < 9) q = $urandom_range(0, 40);
        else q = $urandom;
        send(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, q);
      end else begin
        send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom);
      end
    end
    wait_drained();

    // last part, no idling: empty the table, then check order reuse after empty frames
    idle_en = 1'b0;
    for (k = 0; k < shadow_cnt; k++) live_ids = {live_ids, shadow_tbl[k].id};
    foreach (live_ids[k])
      send(CMD_TOUCH, live_ids[k], $urandom, $urandom, 1'b0, 1'b1, 1'b0, $urandom);
    send(CMD_FRAME, $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b0, $urandom);
    send(CMD_FRAME, $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b0, $urandom);
    // counter restarts from zero here
    for (k = 0; k < 3; k++)
      send(CMD_TOUCH, 32'hA5A5_0000 + k, $urandom, $urandom, 1'b1, 1'b0, 1'b0, 16'd0);
    send(CMD_QUERY, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'hFFFF);
    send(CMD_QUERY, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd1);
    send(CMD_TOUCH, 32'hA5A5_0002, $urandom, $urandom, 1'b0, 1'b0, 1'b1, 16'd0);
    send(CMD_FRAME, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd0);
    for (k = 0; k < 3; k++)
      send(CMD_TOUCH, 32'hA5A5_0000 + k, 24'd0, 24'd0, 1'b0, 1'b1, 1'b0, 16'd0);
    send(CMD_FRAME, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd0);
    send(CMD_TOUCH, 32'h0000_0042, $urandom, $urandom, 1'b1, 1'b0, 1'b0, 16'd0);
    send(CMD_QUERY, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'hFFFF);
    send(CMD_FRAME, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd0);
    send(CMD_TOUCH, 32'h0000_0042, 24'd0, 24'd0, 1'b0, 1'b1, 1'b0, 16'd0);
    send(CMD_FRAME, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd0);
    send(CMD_FRAME, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd0);
    send(CMD_TOUCH, 32'h0000_0043, $urandom, $urandom, 1'b0, 1'b0, 1'b1, 16'd0);
    send(CMD_QUERY, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 16'd0);
    wait_drained();
    repeat (END_WAIT) @(negedge clk);

    $display("Covered %0d input beats and %0d result beats, %0d full-table drops,",
             n_in, n_out, n_full);
    $display("%0d query misses, receiver hold-off, and order restart on empty frames.",
             n_miss);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results still expected", fail_cnt,
               expected_results.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: touch_contact_table_top.f
rtl/tct_pkg.sv
rtl/tct_mem.sv
rtl/tct_seq.sv
rtl/touch_contact_table_top.sv
sim/tb_touch_contact_table_top.sv
